// ===== rtl/indexed_deque_buffer_assert.svh =====
// assertion macros for the checker of the deque buffer
// needs a clock named clk and an active-low reset named rst_n in the using scope
`ifndef INDEXED_DEQUE_BUFFER_ASSERT_SVH
`define INDEXED_DEQUE_BUFFER_ASSERT_SVH

// same-cycle implication, idle in reset
`define IDB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque buffer check failed");

// next-cycle implication, idle in reset
`define IDB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque buffer check failed");

`endif

// ===== rtl/idb_pkg.sv =====
// shared types and constants of the indexed deque buffer
// no dependencies
package idb_pkg;

    // default geometry
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed field widths of the request and response channels
    localparam int CMD_W   = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;
    localparam int FILL_W  = 5;

    // widest slot index and count over the supported depth range
    localparam int IDX_MAX_W = 8;
    localparam int CNT_MAX_W = 9;

    // request opcodes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_INSERT     = 3'd4,
        CMD_REMOVE     = 3'd5,
        CMD_FETCH      = 3'd6,
        CMD_CONTAINS   = 3'd7
    } cmd_t;

    // per-cycle action broadcast to the cell row
    typedef enum logic [2:0] {
        OP_HOLD         = 3'd0,
        OP_WRITE        = 3'd1,
        OP_OPEN         = 3'd2,
        OP_CLOSE        = 3'd3,
        OP_CLOSE_APPEND = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [IDX_MAX_W-1:0]   idx;
        logic [IDX_MAX_W-1:0]   rd_idx;
        logic [CNT_MAX_W-1:0]   cnt;
    } cell_ctrl_t;

endpackage

// ===== rtl/idb_if.sv =====
// request and response channel interfaces of the indexed deque buffer
// uses idb_pkg for field widths
interface idb_cmd_if;
    import idb_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [VALUE_W-1:0]       value;
    logic signed [POS_W-1:0]  position;

    modport source (output valid, output cmd, output value, output position, input ready);
    modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

interface idb_rsp_if;
    import idb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 ok;
    logic [VALUE_W-1:0]   read_value;
    logic                 found;
    logic [FILL_W-1:0]    fill_count;
    logic                 is_empty;
    logic                 is_full;

    modport source (output valid, output ok, output read_value, output found,
                    output fill_count, output is_empty, output is_full, input ready);
    modport sink   (input valid, input ok, input read_value, input found,
                    input fill_count, input is_empty, input is_full, output ready);
endinterface

// ===== rtl/idb_cell.sv =====
// one slot of the deque: holds an entry, trades with its neighbors on shifts
// uses idb_pkg for the broadcast control struct
module idb_cell #(
    parameter int DEPTH      = idb_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = idb_pkg::DATA_WIDTH_DEF,
    parameter int CELL_IDX   = 0
) (
    input  logic                     clk,
    input  idb_pkg::cell_ctrl_t      ctrl,
    input  logic [DATA_WIDTH-1:0]    value,
    input  logic [DATA_WIDTH-1:0]    data_left,
    input  logic [DATA_WIDTH-1:0]    data_right,
    output logic [DATA_WIDTH-1:0]    data_out,
    output logic [DATA_WIDTH-1:0]    rd_word,
    output logic                     match
);
    import idb_pkg::*;

    localparam logic [IDX_MAX_W-1:0] MY_IDX  = IDX_MAX_W'(CELL_IDX);
    localparam logic [CNT_MAX_W-1:0] MY_CNT  = CNT_MAX_W'(CELL_IDX);
    localparam logic                 IS_LAST = (CELL_IDX == DEPTH - 1);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  held;

    // next entry from the broadcast action
    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            OP_HOLD:
            begin
                data_next = data_reg;
            end
            OP_WRITE:
            begin
                if (MY_IDX == ctrl.idx)
                begin
                    data_next = value;
                end
            end
            OP_OPEN:
            begin
                if (MY_IDX == ctrl.idx)
                begin
                    data_next = value;
                end
                else if (MY_IDX > ctrl.idx)
                begin
                    data_next = data_left;
                end
            end
            OP_CLOSE:
            begin
                if (MY_IDX >= ctrl.idx && !IS_LAST)
                begin
                    data_next = data_right;
                end
            end
            OP_CLOSE_APPEND:
            begin
                data_next = IS_LAST ? value : data_right;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // entry storage, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // read tap and compare against the key
    assign held     = (MY_CNT < ctrl.cnt);
    assign match    = held && (data_reg == value);
    assign rd_word  = (MY_IDX == ctrl.rd_idx) ? data_reg : '0;
    assign data_out = data_reg;

endmodule

// ===== rtl/indexed_deque_buffer.sv =====
// Indexed deque buffer: DEPTH entries of DATA_WIDTH bits in a row of cells,
// slot 0 being the front. One request is taken per clock while responses
// are consumed; its response is registered and appears in the cycle after
// the request is taken, and the next request is taken in that same cycle
// if the response is consumed. Shifting inserts, removes and pushes act at
// once as every cell loads from its neighbor; the contains test and the read
// select are wide OR reductions over the cell row, which set the clock path.
// top level: uses idb_pkg, idb_if and idb_cell
module indexed_deque_buffer #(
    parameter int DEPTH      = idb_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = idb_pkg::DATA_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    idb_cmd_if.sink    cmd_in,
    idb_rsp_if.source  rsp_out
);
    import idb_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int RW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    // control state
    logic              ovw_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              out_valid_reg;

    // response payload
    logic                ok_reg,    ok_next;
    logic [VALUE_W-1:0]  rd_reg,    rd_next;
    logic                found_reg, found_next;

    logic                  accept;
    logic                  full, empty;
    logic [DATA_WIDTH-1:0] key;
    logic signed [RW-1:0]  pos_ext, cnt_s, res;
    logic                  in_cnt, in_cnt1;
    logic [IDX_W-1:0]      res_idx;
    logic [IDX_W-1:0]      idx_sel, rd_sel;
    logic                  rd_en;
    cell_op_t              op_sel;
    cell_ctrl_t            ctrl;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];
    logic [DEPTH-1:0]      cell_match;
    logic [DATA_WIDTH-1:0] rd_or;

    // handshake
    assign cmd_in.ready = !out_valid_reg || rsp_out.ready;
    assign accept       = cmd_in.valid && cmd_in.ready;

    assign full  = (cnt_reg == CNT_FULL);
    assign empty = (cnt_reg == '0);
    assign key   = DATA_WIDTH'(cmd_in.value);

    // position resolution, negative counts back from the end
    always_comb
    begin
        pos_ext = RW'(cmd_in.position);
        cnt_s   = signed'(RW'(cnt_reg));
        res     = (pos_ext < 0) ? (pos_ext + cnt_s) : pos_ext;
        in_cnt  = (res >= 0) && (res < cnt_s);
        in_cnt1 = (res >= 0) && (res <= cnt_s);
        res_idx = IDX_W'(res);
    end

    // request decode
    always_comb
    begin
        op_sel     = OP_HOLD;
        idx_sel    = '0;
        rd_sel     = '0;
        rd_en      = 1'b0;
        ok_next    = 1'b0;
        found_next = 1'b0;
        cnt_next   = cnt_reg;
        unique case (cmd_t'(cmd_in.cmd))
            CMD_PUSH_FRONT:
            begin
                if (!full || ovw_reg)
                begin
                    op_sel   = OP_OPEN;
                    ok_next  = 1'b1;
                    cnt_next = full ? cnt_reg : cnt_reg + 1'b1;
                end
            end
            CMD_PUSH_BACK:
            begin
                if (!full)
                begin
                    op_sel   = OP_WRITE;
                    idx_sel  = IDX_W'(cnt_reg);
                    ok_next  = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (ovw_reg)
                begin
                    op_sel  = OP_CLOSE_APPEND;
                    ok_next = 1'b1;
                end
            end
            CMD_POP_FRONT:
            begin
                if (!empty)
                begin
                    op_sel   = OP_CLOSE;
                    rd_en    = 1'b1;
                    ok_next  = 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            CMD_POP_BACK:
            begin
                if (!empty)
                begin
                    rd_sel   = IDX_W'(cnt_reg - 1'b1);
                    rd_en    = 1'b1;
                    ok_next  = 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            CMD_INSERT:
            begin
                if (ovw_reg)
                begin
                    if (in_cnt)
                    begin
                        op_sel  = OP_WRITE;
                        idx_sel = res_idx;
                        ok_next = 1'b1;
                    end
                end
                else if (!full && in_cnt1)
                begin
                    op_sel   = OP_OPEN;
                    idx_sel  = res_idx;
                    ok_next  = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (in_cnt)
                begin
                    op_sel   = OP_CLOSE;
                    idx_sel  = res_idx;
                    rd_sel   = res_idx;
                    rd_en    = 1'b1;
                    ok_next  = 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            CMD_FETCH:
            begin
                if (in_cnt)
                begin
                    rd_sel  = res_idx;
                    rd_en   = 1'b1;
                    ok_next = 1'b1;
                end
            end
            CMD_CONTAINS:
            begin
                ok_next    = 1'b1;
                found_next = |cell_match;
            end
        endcase
    end

    // broadcast to the cells, idle unless a request is taken
    always_comb
    begin
        ctrl.op     = accept ? op_sel : OP_HOLD;
        ctrl.idx    = IDX_MAX_W'(idx_sel);
        ctrl.rd_idx = IDX_MAX_W'(rd_sel);
        ctrl.cnt    = CNT_MAX_W'(cnt_reg);
    end

    // cell row
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_w, right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_data[i+1];
        end

        idb_cell #(
            .DEPTH      (DEPTH),
            .DATA_WIDTH (DATA_WIDTH),
            .CELL_IDX   (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .value      (key),
            .data_left  (left_w),
            .data_right (right_w),
            .data_out   (cell_data[i]),
            .rd_word    (cell_rd[i]),
            .match      (cell_match[i])
        );
    end

    // read select, one tap is live at most
    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_or = rd_or | cell_rd[i];
        end
        rd_next = rd_en ? VALUE_W'(rd_or) : '0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovw_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ovw_reg <= cfg_wdata;
            end
            if (accept)
            begin
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg    <= ok_next;
            rd_reg    <= rd_next;
            found_reg <= found_next;
        end
    end

    assign rsp_out.valid      = out_valid_reg;
    assign rsp_out.ok         = ok_reg;
    assign rsp_out.read_value = rd_reg;
    assign rsp_out.found      = found_reg;
    assign rsp_out.fill_count = FILL_W'(cnt_reg);
    assign rsp_out.is_empty   = (cnt_reg == '0);
    assign rsp_out.is_full    = (cnt_reg == CNT_FULL);

endmodule

// ===== rtl/idb_checker.sv =====
// port-level checks of the indexed deque buffer, bound to the top level
// uses indexed_deque_buffer_assert.svh
module idb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        ok,
    input logic [31:0] read_value,
    input logic        found,
    input logic [4:0]  fill_count,
    input logic        is_empty,
    input logic        is_full
);
`include "indexed_deque_buffer_assert.svh"

    // a stalled response stays offered
    `IDB_ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready, out_valid)
    // every taken request shows its response in the next cycle
    `IDB_ASSERT_NEXT(a_rsp_follows, in_valid && in_ready, out_valid)
    // a hit needs a successful lookup on a non-empty buffer
    `IDB_ASSERT_NOW(a_found_ok, out_valid && found, ok && !is_empty && !is_full || ok && is_full)
    // data only comes back from a successful read
    `IDB_ASSERT_NOW(a_read_ok, out_valid && (read_value != 32'd0), ok)
    // empty flag agrees with the count and excludes full
    `IDB_ASSERT_NOW(a_empty_cnt, out_valid && is_empty, (fill_count == 5'd0) && !is_full)

endmodule

bind indexed_deque_buffer idb_checker u_idb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (cmd_in.valid),
    .in_ready   (cmd_in.ready),
    .out_valid  (rsp_out.valid),
    .out_ready  (rsp_out.ready),
    .ok         (rsp_out.ok),
    .read_value (rsp_out.read_value),
    .found      (rsp_out.found),
    .fill_count (rsp_out.fill_count),
    .is_empty   (rsp_out.is_empty),
    .is_full    (rsp_out.is_full)
);
